// ===== hw/rtl/ets_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

   // Fixed field widths of the ports.
   localparam int CITY_W   = 3;
   localparam int WEIGHT_W = 16;
   localparam int COUNT_W  = 4;
   localparam int COST_BITS = 20;

   localparam logic [COST_BITS-1:0] COST_MAX = '1;
   localparam logic [COUNT_W-1:0]   CITY_COUNT_RESET = 4'd8;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_SOLVE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DESCEND,
      ST_LEAF,
      ST_EMIT
   } ets_state_type;

   typedef struct packed {
      logic write_edge;
      logic solve_init;
      logic scan_next;
      logic rd_edge;
      logic rd_home;
      logic descend;
      logic leaf_eval;
      logic backtrack;
      logic emit_start;
      logic emit_next;
   } ets_cmd_type;

   typedef struct packed {
      logic at_leaf;
      logic cand_end;
      logic cand_visited;
      logic at_root;
      logic emit_last;
   } ets_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ets_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ets_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ets_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ets_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_action,
   input  wire logic                 rsp_ready,
   input  wire ets_pkg::ets_sts_type sts,
   output logic                      req_ready,
   output logic                      rsp_valid,
   output ets_pkg::ets_cmd_type      cmd
);
   import ets_pkg::*;

   ets_state_type state_ff;
   ets_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_action == ACT_SOLVE) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.at_leaf) begin
               state_in = ST_LEAF;
            end else if (sts.cand_end) begin
               state_in = sts.at_root ? ST_EMIT : ST_SCAN;
            end else if (!sts.cand_visited) begin
               state_in = ST_DESCEND;
            end
         end
         ST_DESCEND: state_in = ST_SCAN;
         ST_LEAF: state_in = sts.at_root ? ST_EMIT : ST_SCAN;
         ST_EMIT: begin
            if (rsp_ready && sts.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_WRITE) begin
                  cmd.write_edge = 1'b1;
               end else begin
                  cmd.solve_init = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // A full path only needs the closing edge back to city 0.
            if (sts.at_leaf) begin
               cmd.rd_home = 1'b1;
            end else if (sts.cand_end) begin
               if (sts.at_root) begin
                  cmd.emit_start = 1'b1;
               end else begin
                  cmd.backtrack = 1'b1;
               end
            end else if (sts.cand_visited) begin
               cmd.scan_next = 1'b1;
            end else begin
               cmd.rd_edge = 1'b1;
            end
         end
         ST_DESCEND: cmd.descend = 1'b1;
         ST_LEAF: begin
            cmd.leaf_eval = 1'b1;
            if (sts.at_root) begin
               cmd.emit_start = 1'b1;
            end else begin
               cmd.backtrack = 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready && !sts.emit_last) begin
               cmd.emit_next = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ets_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ets_dp #(
   parameter int MAX_CITIES  = 8,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ets_pkg::ets_cmd_type            cmd,
   output ets_pkg::ets_sts_type                 sts,
   input  wire logic [ets_pkg::CITY_W-1:0]      req_city_a,
   input  wire logic [ets_pkg::CITY_W-1:0]      req_city_b,
   input  wire logic [ets_pkg::WEIGHT_W-1:0]    req_weight,
   input  wire logic                            csr_valid,
   input  wire logic [ets_pkg::COUNT_W-1:0]     csr_city_count,
   output logic      [ets_pkg::CITY_W-1:0]      rsp_tour_city,
   output logic      [ets_pkg::COST_BITS-1:0]   rsp_tour_cost,
   output logic                                 rsp_last_city
);
   import ets_pkg::*;

   localparam int CB    = $clog2(MAX_CITIES);
   localparam int CW    = $clog2(MAX_CITIES + 1);
   localparam int DEPTH = MAX_CITIES * MAX_CITIES;
   localparam int AW    = $clog2(DEPTH);
   localparam int SUM_W = ((WEIGHT_BITS > COST_BITS) ? WEIGHT_BITS : COST_BITS) + 1;

   // The matrix is symmetric, so only the entry with the lower city first is kept.
   function automatic logic [AW-1:0] edge_addr(input logic [CB-1:0] x,
                                                input logic [CB-1:0] y);
      logic [CB-1:0] lo;
      logic [CB-1:0] hi;
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      edge_addr = AW'(lo) * AW'(MAX_CITIES) + AW'(hi);
   endfunction

   function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                    input logic [WEIGHT_BITS-1:0] b);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(a) + SUM_W'(b);
      sat_add = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_BITS-1:0];
   endfunction

   logic [COUNT_W-1:0]     city_count_ff, city_count_in;
   logic [DEPTH-1:0]       edge_valid_ff, edge_valid_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [CW-1:0]          n_ff, n_in;
   logic [CB-1:0]          depth_ff, depth_in;
   logic [CB-1:0]          cur_ff, cur_in;
   logic [CW-1:0]          cand_ff, cand_in;
   logic [MAX_CITIES-1:0]  visited_ff, visited_in;
   logic [COST_BITS-1:0]   cost_ff, cost_in;
   logic [CB-1:0]          path_ff [MAX_CITIES];
   logic [CB-1:0]          path_in [MAX_CITIES];
   logic [COST_BITS-1:0]   lvl_cost_ff [MAX_CITIES];
   logic [COST_BITS-1:0]   lvl_cost_in [MAX_CITIES];
   logic [CB-1:0]          best_tour_ff [MAX_CITIES];
   logic [CB-1:0]          best_tour_in [MAX_CITIES];
   logic [COST_BITS-1:0]   best_total_ff, best_total_in;
   logic                   best_valid_ff, best_valid_in;
   logic [CW-1:0]          emit_idx_ff, emit_idx_in;

   logic                   wr_ok;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [WEIGHT_BITS-1:0] rd_data;
   logic [WEIGHT_BITS-1:0] edge_weight;
   logic [COST_BITS-1:0]   step_cost;
   logic [CB-1:0]          depth_up;
   logic [CB-1:0]          depth_dn;
   logic [CB-1:0]          cand_city;

   assign wr_ok = (32'(req_city_a) < MAX_CITIES) && (32'(req_city_b) < MAX_CITIES);
   assign wr_en = cmd.write_edge && wr_ok;
   assign wr_addr = edge_addr(CB'(req_city_a), CB'(req_city_b));
   assign cand_city = cand_ff[CB-1:0];
   assign rd_en = cmd.rd_edge || cmd.rd_home;
   assign rd_addr = edge_addr(cur_ff, cmd.rd_home ? CB'(0) : cand_city);

   ets_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (WEIGHT_BITS'(req_weight)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // An entry never written since reset reads as zero.
   assign edge_weight = rd_valid_ff ? rd_data : '0;
   assign step_cost = sat_add(cost_ff, edge_weight);
   assign depth_up = depth_ff + 1'b1;
   assign depth_dn = depth_ff - 1'b1;

   always_comb begin
      sts.at_leaf      = (CW'(depth_ff) + 1'b1) >= n_ff;
      sts.cand_end     = cand_ff >= n_ff;
      sts.cand_visited = !sts.cand_end && visited_ff[cand_city];
      sts.at_root      = depth_ff == '0;
      sts.emit_last    = emit_idx_ff == n_ff;
   end

   always_comb begin
      city_count_in = city_count_ff;
      edge_valid_in = edge_valid_ff;
      rd_valid_in   = rd_valid_ff;
      n_in          = n_ff;
      depth_in      = depth_ff;
      cur_in        = cur_ff;
      cand_in       = cand_ff;
      visited_in    = visited_ff;
      cost_in       = cost_ff;
      path_in       = path_ff;
      lvl_cost_in   = lvl_cost_ff;
      best_tour_in  = best_tour_ff;
      best_total_in = best_total_ff;
      best_valid_in = best_valid_ff;
      emit_idx_in   = emit_idx_ff;

      if (csr_valid) begin
         city_count_in = csr_city_count;
      end
      if (wr_en) begin
         edge_valid_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_valid_in = edge_valid_ff[rd_addr];
      end
      if (cmd.solve_init) begin
         if (city_count_ff == '0) begin
            n_in = CW'(1);
         end else if (32'(city_count_ff) > MAX_CITIES) begin
            n_in = CW'(MAX_CITIES);
         end else begin
            n_in = CW'(city_count_ff);
         end
         depth_in       = '0;
         cur_in         = '0;
         cand_in        = CW'(1);
         visited_in     = MAX_CITIES'(1);
         cost_in        = '0;
         path_in[0]     = '0;
         lvl_cost_in[0] = '0;
         best_valid_in  = 1'b0;
         best_total_in  = COST_MAX;
      end
      if (cmd.scan_next) begin
         cand_in = cand_ff + 1'b1;
      end
      if (cmd.descend) begin
         path_in[depth_up]     = cand_city;
         lvl_cost_in[depth_up] = step_cost;
         visited_in[cand_city] = 1'b1;
         depth_in              = depth_up;
         cur_in                = cand_city;
         cost_in               = step_cost;
         cand_in               = CW'(1);
      end
      // The first complete tour of a solve is always taken.
      if (cmd.leaf_eval && (!best_valid_ff || step_cost < best_total_ff)) begin
         best_valid_in = 1'b1;
         best_total_in = step_cost;
         best_tour_in  = path_ff;
      end
      // On return the parent resumes its scan just past the city that was left.
      if (cmd.backtrack) begin
         depth_in           = depth_dn;
         visited_in[cur_ff] = 1'b0;
         cand_in            = CW'(cur_ff) + 1'b1;
         cur_in             = path_ff[depth_dn];
         cost_in            = lvl_cost_ff[depth_dn];
      end
      if (cmd.emit_start) begin
         emit_idx_in = '0;
      end
      if (cmd.emit_next) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CITY_COUNT_RESET;
         edge_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         city_count_ff <= city_count_in;
         edge_valid_ff <= edge_valid_in;
         rd_valid_ff   <= rd_valid_in;
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      depth_ff      <= depth_in;
      cur_ff        <= cur_in;
      cand_ff       <= cand_in;
      visited_ff    <= visited_in;
      cost_ff       <= cost_in;
      path_ff       <= path_in;
      lvl_cost_ff   <= lvl_cost_in;
      best_tour_ff  <= best_tour_in;
      best_total_ff <= best_total_in;
      emit_idx_ff   <= emit_idx_in;
   end

   assign rsp_tour_city = sts.emit_last ? '0 : CITY_W'(best_tour_ff[emit_idx_ff[CB-1:0]]);
   assign rsp_tour_cost = best_total_ff;
   assign rsp_last_city = sts.emit_last;

endmodule

`default_nettype wire

// ===== hw/rtl/exhaustive_tsp_solver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Brute-force travelling-salesman search over a stored symmetric weight matrix.
// The req channel carries two kinds of item: an edge write (action 0) stores a
// weight for city_a/city_b; a solve (action 1) searches every closed tour from
// city 0 over the csr_city_count cities in use and then sends city_count+1 items
// on the rsp channel, the tour in order and the return to city 0 with
// rsp_last_city set, each carrying the tour's total cost.
// The csr channel is always ready and should only be written while idle.
// A city count of zero is taken as one, and one above MAX_CITIES as MAX_CITIES.
// A solve scans the candidate cities at each level, descends, closes each level
// and evaluates each complete tour through the single matrix read port, then
// sends the results in order, each held until rsp_ready takes it.
// Only one item is in flight: req_ready is low from a solve's acceptance until
// its last result is taken, and a stalled rsp_ready simply holds the current
// result. A synchronous reset clears the matrix to zero through per-entry
// valid bits and sets the city count to eight.
module exhaustive_tsp_solver #(
   parameter int MAX_CITIES  = 8,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_action,
   input  wire logic [ets_pkg::CITY_W-1:0]    req_city_a,
   input  wire logic [ets_pkg::CITY_W-1:0]    req_city_b,
   input  wire logic [ets_pkg::WEIGHT_W-1:0]  req_weight,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [ets_pkg::CITY_W-1:0]    rsp_tour_city,
   output logic      [ets_pkg::COST_BITS-1:0] rsp_tour_cost,
   output logic                               rsp_last_city,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ets_pkg::COUNT_W-1:0]   csr_city_count
);
   import ets_pkg::*;

   ets_cmd_type cmd;
   ets_sts_type sts;

   assign csr_ready = 1'b1;

   ets_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .rsp_ready  (rsp_ready),
      .sts        (sts),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   ets_dp #(
      .MAX_CITIES  (MAX_CITIES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_city_a     (req_city_a),
      .req_city_b     (req_city_b),
      .req_weight     (req_weight),
      .csr_valid      (csr_valid),
      .csr_city_count (csr_city_count),
      .rsp_tour_city  (rsp_tour_city),
      .rsp_tour_cost  (rsp_tour_cost),
      .rsp_last_city  (rsp_last_city)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ets_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ets_check (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ets_pkg::CITY_W-1:0]    rsp_tour_city,
   input wire logic [ets_pkg::COST_BITS-1:0] rsp_tour_cost,
   input wire logic                          rsp_last_city
);

   // Only one item is ever in flight, so input is closed while results go out.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high while a result is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tour_city)
         && $stable(rsp_tour_cost) && $stable(rsp_last_city))
      else $error("stalled result changed");

   // All results of one solve follow back to back and share the total cost.
   a_cost_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_city |=> rsp_valid && $stable(rsp_tour_cost))
      else $error("tour cost changed within one tour");

   a_return_home: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_city |-> rsp_tour_city == '0)
      else $error("final item is not the return to city 0");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_city |=> !rsp_valid && req_ready)
      else $error("block not idle after the final result");

endmodule

bind exhaustive_tsp_solver ets_check u_ets_check (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_tour_city (rsp_tour_city),
   .rsp_tour_cost (rsp_tour_cost),
   .rsp_last_city (rsp_last_city)
);

`default_nettype wire

// ===== sim/exhaustive_tsp_solver_tb.sv =====
`timescale 1ns / 1ps

module exhaustive_tsp_solver_tb;

   import ets_pkg::*;

   localparam int MAX_GAP   = 20;
   localparam int MAX_STALL = 10;

   typedef struct {
      logic                action;
      logic [CITY_W-1:0]   city_a;
      logic [CITY_W-1:0]   city_b;
      logic [WEIGHT_W-1:0] weight;
   } tsp_req_type;

   typedef struct {
      logic [CITY_W-1:0]    city;
      logic [COST_BITS-1:0] cost;
      logic                 last;
   } tour_step_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = ACT_WRITE;
   logic [CITY_W-1:0]     req_city_a = '0;
   logic [CITY_W-1:0]     req_city_b = '0;
   logic [WEIGHT_W-1:0]   req_weight = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CITY_W-1:0]     rsp_tour_city;
   logic [COST_BITS-1:0]  rsp_tour_cost;
   logic                  rsp_last_city;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_city_count = CITY_COUNT_RESET;

   // Predictor state: the weight matrix and the city count as the block should hold them.
   logic [WEIGHT_W-1:0]   edge_w [0:7][0:7];
   logic [COUNT_W-1:0]    cfg_city_count = CITY_COUNT_RESET;

   tsp_req_type   req_backlog[$];
   tour_step_type expected_tour[$];
   tsp_req_type   driver_item;
   tour_step_type want;

   logic        req_taken = 1'b0;
   logic        csr_taken = 1'b0;
   int          gap_left = 0;
   int          burst_left = 0;
   int          stall_left = 0;
   int          stall_tick = 0;
   rx_mode_type stall_mode = RX_OPEN;
   int          fault_count = 0;
   longint      cycle_count = 0;
   longint      work_budget = 2000;

   exhaustive_tsp_solver uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_city_a     (req_city_a),
      .req_city_b     (req_city_b),
      .req_weight     (req_weight),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tour_city  (rsp_tour_city),
      .rsp_tour_cost  (rsp_tour_cost),
      .rsp_last_city  (rsp_last_city),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_city_count (csr_city_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int active_cities(logic [COUNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > 8) return 8;
      return int'(count);
   endfunction

   function automatic logic [COST_BITS-1:0] cost_add(logic [COST_BITS-1:0] x,
                                                     logic [WEIGHT_W-1:0] w);
      logic [COST_BITS:0] s;
      s = x + w;
      return (s > COST_MAX) ? COST_MAX : s[COST_BITS-1:0];
   endfunction

   // Upper bound on search cycles: every node of the search tree, each with a full scan.
   function automatic longint solve_cycle_bound(int n);
      longint nodes;
      longint term;
      nodes = 0;
      term = 1;
      for (int d = 0; d < n; d++) begin
         nodes += term;
         term *= (n - 1 - d);
      end
      return nodes * (n + 3) + 64;
   endfunction

   // Walks the tours in lexicographic order of the cities after the start, which is the
   // order of an ascending depth-first search, and keeps the first strictly cheapest one.
   task automatic predict_best_tour();
      int n;
      int perm [0:7];
      int best [0:7];
      int i;
      int j;
      int t;
      int lo;
      int hi;
      bit more;
      bit have_best;
      logic [COST_BITS-1:0] total;
      logic [COST_BITS-1:0] best_total;
      tour_step_type step;
      n = active_cities(cfg_city_count);
      for (i = 0; i < 8; i++) begin
         perm[i] = i;
         best[i] = 0;
      end
      have_best = 1'b0;
      best_total = COST_MAX;
      more = 1'b1;
      while (more) begin
         total = '0;
         for (i = 1; i < n; i++) total = cost_add(total, edge_w[perm[i-1]][perm[i]]);
         total = cost_add(total, edge_w[perm[n-1]][0]);
         if (!have_best || total < best_total) begin
            have_best = 1'b1;
            best_total = total;
            best = perm;
         end
         i = n - 2;
         while (i >= 1 && perm[i] >= perm[i+1]) i--;
         if (i < 1) begin
            more = 1'b0;
         end else begin
            j = n - 1;
            while (perm[j] <= perm[i]) j--;
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
            lo = i + 1;
            hi = n - 1;
            while (lo < hi) begin
               t = perm[lo];
               perm[lo] = perm[hi];
               perm[hi] = t;
               lo++;
               hi--;
            end
         end
      end
      for (int k = 0; k <= n; k++) begin
         step.city = (k < n) ? best[k][CITY_W-1:0] : '0;
         step.cost = best_total;
         step.last = (k == n);
         expected_tour = {expected_tour, step};
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // The item waits for the block.
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
         driver_item = req_backlog.pop_front();
         req_valid <= 1'b1;
         req_action <= driver_item.action;
         req_city_a <= driver_item.city_a;
         req_city_b <= driver_item.city_b;
         req_weight <= driver_item.weight;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, MAX_GAP)
                                                    : $urandom_range(0, 4);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: the stall pattern is redrawn at random periodically.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 40 == 0) stall_mode <= rx_mode_type'($urandom_range(0, 3));
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         case (stall_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= (stall_tick % 4 == 3);
            default: begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, MAX_STALL);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
         cfg_city_count = CITY_COUNT_RESET;
         for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) edge_w[r][c] = '0;
         end
      end else begin
         req_taken <= req_valid && req_ready;
         csr_taken <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) cfg_city_count = csr_city_count;
         if (req_valid && req_ready) begin
            if (req_action == ACT_WRITE) begin
               edge_w[req_city_a][req_city_b] = req_weight;
               edge_w[req_city_b][req_city_a] = req_weight;
            end else begin
               predict_best_tour();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_tour.size() == 0) begin
               $display("%0t: unexpected result, city %0d cost %0d last %0b", $time,
                        rsp_tour_city, rsp_tour_cost, rsp_last_city);
               fault_count++;
            end else begin
               want = expected_tour.pop_front();
               if (rsp_tour_city !== want.city) begin
                  $display("%0t: tour_city expected %0d actual %0d", $time,
                           want.city, rsp_tour_city);
                  fault_count++;
               end
               if (rsp_tour_cost !== want.cost) begin
                  $display("%0t: tour_cost expected %0d actual %0d", $time,
                           want.cost, rsp_tour_cost);
                  fault_count++;
               end
               if (rsp_last_city !== want.last) begin
                  $display("%0t: last_city expected %0b actual %0b", $time,
                           want.last, rsp_last_city);
                  fault_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * work_budget + 20000) begin
         $display("%0t: timed out with %0d results outstanding", $time,
                  expected_tour.size());
         $display("FAIL exhaustive_tsp_solver");
         $finish;
      end
   end

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return WEIGHT_W'($urandom_range(0, 3));
         3:       return WEIGHT_W'($urandom_range(0, 15));
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   task automatic add_write(input int a, input int b, input logic [WEIGHT_W-1:0] w);
      tsp_req_type item;
      item.action = ACT_WRITE;
      item.city_a = a[CITY_W-1:0];
      item.city_b = b[CITY_W-1:0];
      item.weight = w;
      req_backlog = {req_backlog, item};
      work_budget += MAX_GAP + 4;
   endtask

   task automatic add_solve();
      tsp_req_type item;
      int n;
      n = active_cities(cfg_city_count);
      item.action = ACT_SOLVE;
      item.city_a = CITY_W'($urandom);
      item.city_b = CITY_W'($urandom);
      item.weight = WEIGHT_W'($urandom);
      req_backlog = {req_backlog, item};
      work_budget += MAX_GAP + 4 + solve_cycle_bound(n) + (n + 1) * (MAX_STALL + 8);
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || expected_tour.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_city_count(input logic [COUNT_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_city_count <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
      work_budget += 64;
   endtask

   // Mostly edges among the cities in use followed by a solve; some writes land anywhere.
   task automatic run_phase();
      int n;
      int solves;
      int writes;
      n = active_cities(cfg_city_count);
      solves = (n >= 8) ? 1 : (n == 7) ? 2 : (n == 6) ? 3 : 6;
      for (int s = 0; s < solves; s++) begin
         if (n >= 7) begin
            for (int i = 0; i < n; i++) begin
               for (int j = i + 1; j < n; j++) add_write(i, j, pick_weight());
            end
         end else begin
            writes = $urandom_range(0, 8);
            for (int k = 0; k < writes; k++) begin
               if ($urandom_range(0, 5) == 0)
                  add_write($urandom_range(0, 7), $urandom_range(0, 7),
                            WEIGHT_W'($urandom));
               else
                  add_write($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight());
            end
         end
         add_solve();
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] plan [0:15];
      plan = '{4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd15, 4'd3, 4'd4,
               4'd5, 4'd2, 4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd5};
      plan[5] = COUNT_W'($urandom_range(9, 15));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A solve straight after reset sees an all-zero matrix over eight cities.
      add_solve();

      // Four cities with two equally cheap tours, so the first in order must win.
      write_city_count(4'd4);
      add_write(0, 1, 16'hFFFF);
      add_write(1, 0, 16'h0000);
      add_write(0, 2, 16'hFFFF);
      add_write(0, 3, 16'd3);
      add_write(1, 2, 16'd3);
      add_write(3, 1, 16'hFFFF);
      add_write(2, 3, 16'h0000);
      add_write(2, 2, 16'hFFFF);
      add_write(7, 5, 16'hFFFF);
      add_write(0, 7, 16'd1);
      add_solve();
      add_solve();

      // A zero count behaves as one city: the tour is the start twice over its diagonal.
      write_city_count(4'd0);
      add_write(0, 0, 16'd1234);
      add_solve();
      write_city_count(4'd1);
      add_solve();
      add_write(0, 0, 16'hFFFF);
      add_solve();

      foreach (plan[p]) begin
         write_city_count(plan[p]);
         run_phase();
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (fault_count == 0)
         $display("PASS exhaustive_tsp_solver");
      else
         $display("FAIL exhaustive_tsp_solver");
      $finish;
   end

endmodule
